### design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every clock edge outside reset
`define ZBU_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// condition that must never be seen outside reset
`define ZBU_ASSERT_NEVER(label, clk, rst, cond, msg) \
   `ZBU_ASSERT_IMPL(label, clk, rst, 1'b1, !(cond), msg)

`endif

### design/zbu_pkg.sv
package zbu_pkg;

   localparam logic [7:0] RAW_MARK    = 8'hFF;
   localparam int         GROUP_BYTES = 8;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_stream;
   } req_type;

   // results caused by one request: optional data byte, a zero run, optional truncation
   typedef struct packed {
      logic       has_data;
      logic [7:0] data;
      logic [3:0] zeros;
      logic       trunc;
      logic       eos;
      logic       any;
   } burst_type;

endpackage

### design/zbu_ifs.sv
interface zbu_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       end_of_stream;

   modport source (output valid, output in_byte, output end_of_stream, input ready);
   modport sink   (input valid, input in_byte, input end_of_stream, output ready);
endinterface

interface zbu_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       last_of_item;
   logic       stream_done;
   logic       truncated;

   modport source (output valid, output out_byte, output last_of_item,
                   output stream_done, output truncated, input ready);
   modport sink   (input valid, input out_byte, input last_of_item,
                   input stream_done, input truncated, output ready);
endinterface

### design/zbu_decode.sv
module zbu_decode (
   input  logic               clock,
   input  logic               reset,
   input  zbu_pkg::req_type   req,
   input  logic               accept,
   output zbu_pkg::burst_type desc
);

   localparam logic [1:0] MODE_HEADER = 2'd0;
   localparam logic [1:0] MODE_MASK   = 2'd1;
   localparam logic [1:0] MODE_COUNT  = 2'd2;
   localparam logic [1:0] MODE_RAW    = 2'd3;
   localparam logic [3:0] POS_END     = 4'(zbu_pkg::GROUP_BYTES);

   logic [1:0]  mode_ff, mode_in;
   logic [7:0]  mask_ff, mask_in;
   logic [3:0]  pos_ff, pos_in;
   logic [11:0] raw_left_ff, raw_left_in;
   logic [3:0]  pos_next;
   logic [3:0]  run;
   logic [8:0]  count_plus;
   logic [11:0] raw_dec;

   // clear bits of the mask from start upward, up to the next set bit
   function automatic logic [3:0] zero_run(logic [7:0] mask, logic [3:0] start);
      logic [3:0] n;
      logic       stop;
      n    = '0;
      stop = 1'b0;
      for (int i = 0; i < zbu_pkg::GROUP_BYTES; i++) begin
         if (!stop && (4'(i) >= start)) begin
            if (mask[i]) stop = 1'b1;
            else n = n + 4'd1;
         end
      end
      return n;
   endfunction

   always_comb begin
      mode_in     = mode_ff;
      mask_in     = mask_ff;
      pos_in      = pos_ff;
      raw_left_in = raw_left_ff;
      pos_next    = '0;
      run         = '0;
      count_plus  = {1'b0, req.in_byte} + 9'd1;
      raw_dec     = raw_left_ff - 12'd1;
      desc        = '0;
      desc.data   = req.in_byte;
      desc.eos    = req.end_of_stream;

      unique case (mode_ff)
         MODE_HEADER: begin
            if (req.in_byte == zbu_pkg::RAW_MARK) begin
               mode_in = MODE_COUNT;
            end else begin
               run        = zero_run(req.in_byte, 4'd0);
               mask_in    = req.in_byte;
               pos_in     = run;
               desc.zeros = run;
               mode_in    = (run == POS_END) ? MODE_HEADER : MODE_MASK;
            end
         end
         MODE_MASK: begin
            desc.has_data = 1'b1;
            pos_next      = {1'b0, pos_ff[2:0]} + 4'd1;
            run           = zero_run(mask_ff, pos_next);
            pos_in        = pos_next + run;
            desc.zeros    = run;
            mode_in       = (pos_in == POS_END) ? MODE_HEADER : MODE_MASK;
         end
         MODE_COUNT: begin
            raw_left_in = {count_plus, 3'b000};
            mode_in     = MODE_RAW;
         end
         MODE_RAW: begin
            desc.has_data = 1'b1;
            raw_left_in   = raw_dec;
            if (raw_dec == '0) mode_in = MODE_HEADER;
         end
         default: mode_in = MODE_HEADER;
      endcase

      if (req.end_of_stream) begin
         desc.trunc  = (mode_in != MODE_HEADER);
         mode_in     = MODE_HEADER;
         mask_in     = '0;
         pos_in      = '0;
         raw_left_in = '0;
      end

      desc.any = desc.has_data | (desc.zeros != '0) | desc.trunc;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_HEADER;
         mask_ff     <= '0;
         pos_ff      <= '0;
         raw_left_ff <= '0;
      end else if (accept) begin
         mode_ff     <= mode_in;
         mask_ff     <= mask_in;
         pos_ff      <= pos_in;
         raw_left_ff <= raw_left_in;
      end
   end

endmodule

### design/zbu_emit.sv
module zbu_emit (
   input  logic               clock,
   input  logic               reset,
   input  zbu_pkg::burst_type desc,
   input  logic               load,
   output logic               free,
   zbu_rsp_if.source          rsp_if
);

   logic       busy_ff, busy_in;
   logic       has_data_ff, has_data_in;
   logic [7:0] data_ff, data_in;
   logic [3:0] zeros_ff, zeros_in;
   logic       trunc_ff, trunc_in;
   logic       eos_ff, eos_in;

   logic       out_valid_ff, out_valid_in;
   logic [7:0] out_byte_ff, out_byte_in;
   logic       out_last_ff, out_last_in;
   logic       out_done_ff, out_done_in;
   logic       out_trunc_ff, out_trunc_in;

   logic       out_load;
   logic       emit;
   logic       fin;

   always_comb begin
      out_load = !out_valid_ff || rsp_if.ready;
      emit     = busy_ff && out_load;

      // is the result going out now the last of this request
      if (has_data_ff)          fin = (zeros_ff == '0) && !trunc_ff;
      else if (zeros_ff != '0)  fin = (zeros_ff == 4'd1) && !trunc_ff;
      else                      fin = 1'b1;

      free = !busy_ff || (emit && fin);

      busy_in     = busy_ff;
      has_data_in = has_data_ff;
      data_in     = data_ff;
      zeros_in    = zeros_ff;
      trunc_in    = trunc_ff;
      eos_in      = eos_ff;
      if (load) begin
         busy_in     = 1'b1;
         has_data_in = desc.has_data;
         data_in     = desc.data;
         zeros_in    = desc.zeros;
         trunc_in    = desc.trunc;
         eos_in      = desc.eos;
      end else if (emit) begin
         if (fin) busy_in = 1'b0;
         else if (has_data_ff) has_data_in = 1'b0;
         else zeros_in = zeros_ff - 4'd1;
      end

      out_valid_in = out_valid_ff;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      out_done_in  = out_done_ff;
      out_trunc_in = out_trunc_ff;
      if (emit) begin
         out_valid_in = 1'b1;
         out_byte_in  = has_data_ff ? data_ff : 8'h00;
         out_trunc_in = !has_data_ff && (zeros_ff == '0);
         out_last_in  = fin;
         out_done_in  = fin && eos_ff;
      end else if (rsp_if.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
      end
      has_data_ff  <= has_data_in;
      data_ff      <= data_in;
      zeros_ff     <= zeros_in;
      trunc_ff     <= trunc_in;
      eos_ff       <= eos_in;
      out_byte_ff  <= out_byte_in;
      out_last_ff  <= out_last_in;
      out_done_ff  <= out_done_in;
      out_trunc_ff <= out_trunc_in;
   end

   assign rsp_if.valid        = out_valid_ff;
   assign rsp_if.out_byte     = out_byte_ff;
   assign rsp_if.last_of_item = out_last_ff;
   assign rsp_if.stream_done  = out_done_ff;
   assign rsp_if.truncated    = out_trunc_ff;

endmodule

### design/zero_byte_unpacker.sv
// first result of a request: result queue stage, then output register
// throughput: one request per cycle while each yields at most one result and the
// output is not stalled; a request with several results holds the result queue stage
// (one result per cycle leaves the output register unless stalled), stalling requests
// reset: synchronous, clears decode state and empties both stages
`include "assert_macros.svh"

module zero_byte_unpacker (
   input  logic      clock,
   input  logic      reset,
   zbu_req_if.sink   req_if,
   zbu_rsp_if.source rsp_if
);

   zbu_pkg::req_type   req;
   zbu_pkg::burst_type desc;
   logic               accept;
   logic               load;
   logic               free;

   assign req.in_byte       = req_if.in_byte;
   assign req.end_of_stream = req_if.end_of_stream;
   assign req_if.ready      = free;
   assign accept            = req_if.valid && free;
   assign load              = accept && desc.any;

   zbu_decode u_decode (
      .clock  (clock),
      .reset  (reset),
      .req    (req),
      .accept (accept),
      .desc   (desc)
   );

   zbu_emit u_emit (
      .clock  (clock),
      .reset  (reset),
      .desc   (desc),
      .load   (load),
      .free   (free),
      .rsp_if (rsp_if)
   );

   `ZBU_ASSERT_IMPL(a_done_is_last, clock, reset, rsp_if.valid && rsp_if.stream_done, rsp_if.last_of_item, "stream_done without last_of_item")
   `ZBU_ASSERT_IMPL(a_trunc_form, clock, reset, rsp_if.valid && rsp_if.truncated, (rsp_if.out_byte == 8'h00) && rsp_if.stream_done, "malformed truncation request")
   `ZBU_ASSERT_IMPL(a_burst_bound, clock, reset, accept && desc.has_data, desc.zeros <= 4'd7, "zero run too long after data byte")
   `ZBU_ASSERT_IMPL(a_load_needs_free, clock, reset, load, free, "burst loaded while emitter busy")

endmodule

### bench/zero_byte_unpacker_test.sv
`timescale 1ns / 100ps

module zero_byte_unpacker_test;

   typedef enum logic [1:0] {
      WANT_HEADER,
      WANT_DATA,
      WANT_COUNT,
      COPY_RAW
   } unpack_state_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_of_item;
      logic       stream_done;
      logic       truncated;
   } decoded_type;

   logic clock = 1'b0;
   logic reset;

   zbu_req_if req_bus ();
   zbu_rsp_if rsp_bus ();

   zero_byte_unpacker u_top (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus)
   );

   // decoder state as the block should hold it
   unpack_state_type unpack_state;
   logic [7:0]       group_mask;
   logic [3:0]       mask_bit;
   logic [11:0]      raw_left;

   decoded_type decoded_due[$];
   int          error_count;
   int          requests_sent;
   int          send_idle_pct;
   int          rsp_stall_pct;
   int          hold_cycles;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      #2_000_000;
      $display("zero_byte_unpacker_test: done, errors");
      $finish;
   end

   function automatic void clear_decoder();
      unpack_state = WANT_HEADER;
      group_mask   = '0;
      mask_bit     = '0;
      raw_left     = '0;
   endfunction

   // zeros for the clear mask bits up to the next set one
   function automatic void push_zero_run();
      while (mask_bit < zbu_pkg::GROUP_BYTES && !group_mask[mask_bit[2:0]]) begin
         decoded_due.push_back('{8'h00, 1'b0, 1'b0, 1'b0});
         mask_bit = mask_bit + 4'd1;
      end
      unpack_state = (mask_bit >= zbu_pkg::GROUP_BYTES) ? WANT_HEADER : WANT_DATA;
   endfunction

   function automatic void decode_request(input logic [7:0] in_byte, input logic eos);
      int          first;
      int          run_len;
      decoded_type tail;
      first = decoded_due.size();
      case (unpack_state)
         WANT_HEADER: begin
            if (in_byte == zbu_pkg::RAW_MARK) begin
               unpack_state = WANT_COUNT;
            end else begin
               group_mask = in_byte;
               mask_bit   = '0;
               push_zero_run();
            end
         end
         WANT_DATA: begin
            decoded_due.push_back('{in_byte, 1'b0, 1'b0, 1'b0});
            mask_bit = {1'b0, mask_bit[2:0]} + 4'd1;
            push_zero_run();
         end
         WANT_COUNT: begin
            run_len  = (int'(in_byte) + 1) * zbu_pkg::GROUP_BYTES;
            raw_left = run_len[11:0];
            if (raw_left == '0) raw_left = 12'h800;
            unpack_state = COPY_RAW;
         end
         default: begin
            decoded_due.push_back('{in_byte, 1'b0, 1'b0, 1'b0});
            raw_left = raw_left - 12'd1;
            if (raw_left == '0) unpack_state = WANT_HEADER;
         end
      endcase
      if (eos) begin
         // stream closed inside a group
         if (unpack_state != WANT_HEADER) decoded_due.push_back('{8'h00, 1'b0, 1'b0, 1'b1});
         clear_decoder();
      end
      if (decoded_due.size() > first) begin
         tail = decoded_due.pop_back();
         tail.last_of_item = 1'b1;
         tail.stream_done  = eos;
         decoded_due.push_back(tail);
      end
   endfunction

   always @(posedge clock) begin : check_results
      decoded_type got;
      decoded_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got = '{rsp_bus.out_byte, rsp_bus.last_of_item, rsp_bus.stream_done,
                 rsp_bus.truncated};
         if (decoded_due.size() == 0) begin
            $display("%0t: result with nothing pending, actual byte %02h last %b done %b trunc %b",
                     $time, got.out_byte, got.last_of_item, got.stream_done, got.truncated);
            error_count++;
         end else begin
            want = decoded_due.pop_front();
            if (got.out_byte !== want.out_byte || got.last_of_item !== want.last_of_item ||
                got.stream_done !== want.stream_done || got.truncated !== want.truncated) begin
               $display("%0t: expected byte %02h last %b done %b trunc %b,", $time,
                        want.out_byte, want.last_of_item, want.stream_done, want.truncated,
                        " actual byte %02h last %b done %b trunc %b",
                        got.out_byte, got.last_of_item, got.stream_done, got.truncated);
               error_count++;
            end
         end
      end
   end

   // result side: long hold-off when asked, random stalls otherwise
   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         rsp_bus.ready <= 1'b0;
         hold_cycles   <= hold_cycles - 1;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   task automatic set_idling(input int send_pct, input int stall_pct);
      send_idle_pct = send_pct;
      rsp_stall_pct <= stall_pct;
   endtask

   task automatic send_request(input logic [7:0] in_byte, input logic eos);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.in_byte       <= in_byte;
      req_bus.end_of_stream <= eos;
      do @(posedge clock); while (!req_bus.ready);
      decode_request(in_byte, eos);
      requests_sent++;
   endtask

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (decoded_due.size() != 0) @(posedge clock);
   endtask

   function automatic logic [7:0] random_data();
      logic [7:0] value;
      case ($urandom_range(3))
         0: value = 8'h00;
         1: value = 8'hFF;
         default: value = 8'($urandom_range(255));
      endcase
      return value;
   endfunction

   task automatic send_random_stream();
      logic [7:0] stream[$];
      logic [7:0] mask;
      int         groups;
      int         run_count;
      int         cut;
      logic       close_stream;
      if ($urandom_range(9) == 0) begin
         // lone byte that lands wherever the decoder happens to be
         send_request(random_data(), 1'($urandom_range(1)));
         return;
      end
      groups = $urandom_range(3, 1);
      for (int g = 0; g < groups; g++) begin
         if ($urandom_range(4) == 0) begin
            run_count = ($urandom_range(9) == 0) ? $urandom_range(7, 3) : $urandom_range(1);
            stream.push_back(zbu_pkg::RAW_MARK);
            stream.push_back(run_count[7:0]);
            repeat ((run_count + 1) * zbu_pkg::GROUP_BYTES) stream.push_back(random_data());
         end else begin
            mask = 8'($urandom_range(254));
            stream.push_back(mask);
            for (int i = 0; i < zbu_pkg::GROUP_BYTES; i++) begin
               if (mask[i]) stream.push_back(random_data());
            end
         end
      end
      // now and then the stream stops at a random byte
      if ($urandom_range(4) == 0 && stream.size() > 1) begin
         cut = $urandom_range(stream.size() - 1, 1);
         while (stream.size() > cut) void'(stream.pop_back());
      end
      close_stream = ($urandom_range(9) != 0);
      foreach (stream[i]) send_request(stream[i], close_stream && i == stream.size() - 1);
   endtask

   task automatic run_random_phase(input int send_pct, input int stall_pct, input int count);
      int start;
      set_idling(send_pct, stall_pct);
      start = requests_sent;
      while (requests_sent - start < count) send_random_stream();
      wait_drained();
   endtask

   task automatic test_bitmask_groups();
      set_idling(0, 0);
      send_request(8'h00, 1'b1);
      send_request(8'h80, 1'b0);
      send_request(8'hA5, 1'b0);
      send_request(8'h81, 1'b0);
      send_request(8'h00, 1'b0);
      send_request(8'hFF, 1'b1);
      wait_drained();
   endtask

   task automatic test_raw_run();
      logic [7:0] payload[8] = '{8'h00, 8'hFF, 8'h80, 8'h01, 8'h55, 8'hAA, 8'h7F, 8'hFE};
      set_idling(0, 0);
      send_request(zbu_pkg::RAW_MARK, 1'b0);
      send_request(8'h00, 1'b0);
      foreach (payload[i]) send_request(payload[i], i == 7);
      wait_drained();
   endtask

   task automatic test_truncation();
      set_idling(0, 0);
      // ends right after the raw marker
      send_request(zbu_pkg::RAW_MARK, 1'b1);
      // ends on the count byte, largest count
      send_request(zbu_pkg::RAW_MARK, 1'b0);
      send_request(8'hFF, 1'b1);
      // ends inside a raw run
      send_request(zbu_pkg::RAW_MARK, 1'b0);
      send_request(8'hFF, 1'b0);
      send_request(8'h5A, 1'b0);
      send_request(8'hC3, 1'b1);
      // ends on a header with set bits pending
      send_request(8'h06, 1'b1);
      // ends on a data byte with set bits still to come
      send_request(8'h0A, 1'b0);
      send_request(8'h3C, 1'b1);
      wait_drained();
   endtask

   task automatic test_random_traffic();
      run_random_phase(0, 0, 25);
      run_random_phase(71, 0, 20);
      run_random_phase(0, 71, 20);
      run_random_phase(7, 7, 25);
   endtask

   task automatic test_output_hold_off();
      set_idling(0, 0);
      hold_cycles <= 300;
      // all-zero headers fill the result path fastest
      repeat (6) send_request(8'h00, 1'b0);
      repeat (4) send_random_stream();
      wait_drained();
   endtask

   initial begin
      reset                 = 1'b1;
      req_bus.valid         = 1'b0;
      req_bus.in_byte       = '0;
      req_bus.end_of_stream = 1'b0;
      rsp_bus.ready         = 1'b0;
      error_count           = 0;
      requests_sent         = 0;
      send_idle_pct         = 0;
      rsp_stall_pct         = 0;
      hold_cycles           = 0;
      clear_decoder();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_bitmask_groups();
      test_raw_run();
      test_truncation();
      test_random_traffic();
      test_output_hold_off();

      repeat (10) @(posedge clock);
      if (error_count == 0) begin
         $display("zero_byte_unpacker_test: done, clean");
      end else begin
         $display("zero_byte_unpacker_test: done, errors");
      end
      $finish;
   end

endmodule

### zero_byte_unpacker.f
+incdir+design
design/zbu_pkg.sv
design/zbu_ifs.sv
design/zbu_decode.sv
design/zbu_emit.sv
design/zero_byte_unpacker.sv
bench/zero_byte_unpacker_test.sv
